[sv/cst_pkg.sv]
// Shared types and constants for the client slot table.
package cst_pkg;

	localparam logic [1:0] FUNC_JOIN  = 2'd0;
	localparam logic [1:0] FUNC_LEAVE = 2'd1;
	localparam logic [1:0] FUNC_INPUT = 2'd2;
	localparam logic [1:0] FUNC_TICK  = 2'd3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd300;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_JOIN_SCAN,
		ST_JOIN_READ,
		ST_NAMED_READ,
		ST_NAMED_EXEC,
		ST_TICK,
		ST_RESULT
	} state_t;

	// store command: read strobe and write enables for one cycle
	typedef struct packed {
		logic rd;
		logic ep_we;
		logic idle_we;
		logic btn_we;
		logic used_we;
		logic used_val;
	} st_cmd_t;

endpackage

[sv/cst_alu.sv]
// Shared compare and increment unit: endpoint match, idle aging, timeout test.
module cst_alu (
	input  logic [31:0] st_address,
	input  logic [15:0] st_port,
	input  logic [31:0] address,
	input  logic [15:0] port,
	input  logic [15:0] idle,
	input  logic [15:0] timeout,
	output logic        match,
	output logic [15:0] idle_inc,
	output logic        expired
);
	import cst_pkg::*;

	always_comb begin
		match    = (st_address == address) && (st_port == port);
		idle_inc = (idle == IDLE_MAX) ? idle : idle + 16'd1;
		expired  = idle_inc > timeout;
	end

endmodule

[sv/cst_store.sv]
// Slot storage: endpoint, idle count and button memories plus per-slot flags.
module cst_store #(
	parameter int SLOTS = 4,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cst_pkg::st_cmd_t cmd,
	input  logic [IW-1:0]    rd_idx,
	input  logic [IW-1:0]    wr_idx,
	input  logic [31:0]      wr_address,
	input  logic [15:0]      wr_port,
	input  logic [15:0]      wr_idle,
	input  logic [3:0]       wr_btn,
	output logic [SLOTS-1:0] used,
	output logic [31:0]      rd_address,
	output logic [15:0]      rd_port,
	output logic [15:0]      rd_idle,
	output logic [3:0]       rd_btn
);
	import cst_pkg::*;

	logic [31:0] addr_mem [SLOTS];
	logic [15:0] port_mem [SLOTS];
	logic [15:0] idle_mem [SLOTS];
	logic [3:0]  btn_mem  [SLOTS];

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] btn_set_q;
	logic             rd_used_q;
	logic             rd_btn_set_q;
	logic [31:0]      rd_addr_q;
	logic [3:0]       rd_btn_q;

	// flags: slot in use (address nonzero), button word ever written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			btn_set_q <= '0;
		end else begin
			if (cmd.used_we) used_q[wr_idx] <= cmd.used_val;
			if (cmd.btn_we)  btn_set_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ep_we) begin
			addr_mem[wr_idx] <= wr_address;
			port_mem[wr_idx] <= wr_port;
		end
		if (cmd.idle_we) idle_mem[wr_idx] <= wr_idle;
		if (cmd.btn_we)  btn_mem[wr_idx]  <= wr_btn;
		if (cmd.rd) begin
			rd_addr_q    <= addr_mem[rd_idx];
			rd_port      <= port_mem[rd_idx];
			rd_idle      <= idle_mem[rd_idx];
			rd_btn_q     <= btn_mem[rd_idx];
			rd_used_q    <= used_q[rd_idx];
			rd_btn_set_q <= btn_set_q[rd_idx];
		end
	end

	// a free slot reads as address zero, an unwritten button word as zero
	assign rd_address = rd_used_q ? rd_addr_q : 32'd0;
	assign rd_btn     = rd_btn_set_q ? rd_btn_q : 4'd0;
	assign used       = used_q;

endmodule

[sv/client_slot_table_top.sv]
// Client slot table top level: sequencer, result register and config register.
//
// Session table of SLOTS client slots keyed by (address, port); a slot whose
// address is zero is free. Each accepted word yields exactly one result word.
// Join scans the slots one per cycle for the lowest free one; tick ages the
// used slots one per cycle through the shared increment/compare unit, with
// the idle-count memory read one slot ahead of the update. Leave and input
// read the named slot, then compare and update. The block takes a new word
// only when idle (in_stall high otherwise), and a finished result sits in the
// output register until out_stall drops. timeout_ticks is written through
// cfg_we/cfg_data and resets to 300; the user writes it only while idle, the
// block does not enforce this. A used slot is freed when its idle count
// exceeds timeout_ticks. There is no clearing pass after reset.
module client_slot_table_top #(
	parameter int SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] client_address,
	input  logic [15:0] client_port,
	input  logic [15:0] slot_index,
	input  logic [3:0]  button_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [1:0]  assigned_slot,
	output logic [3:0]  slot_buttons,
	output logic [3:0]  active_mask,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	import cst_pkg::*;

	localparam int            IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	state_t state_q, state_d;

	// latched input word
	logic [1:0]  func_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic [15:0] named_q;
	logic [3:0]  btn_q;

	logic [15:0]   timeout_q;
	logic [IW-1:0] idx_q;      // scan counter
	logic          tick_done_q;
	logic          vld_s1;     // tick slot in update stage
	logic [IW-1:0] idx_s1;

	// pending result
	logic       res_acc_q;
	logic [1:0] res_slot_q;
	logic [3:0] res_btn_q;

	logic        out_valid_q;
	logic        acc_out_q;
	logic [1:0]  slot_out_q;
	logic [3:0]  btn_out_q;
	logic [3:0]  mask_out_q;

	// store interface
	st_cmd_t          cmd;
	logic [IW-1:0]    rd_idx, wr_idx;
	logic [15:0]      wr_idle;
	logic [SLOTS-1:0] used;
	logic [31:0]      rd_address;
	logic [15:0]      rd_port, rd_idle;
	logic [3:0]       rd_btn;

	logic          match, expired;
	logic [15:0]   idle_inc;
	logic          in_range, hit;
	logic [IW-1:0] named_idx;
	logic [3:0]    mask_now;

	cst_store #(.SLOTS(SLOTS), .IW(IW)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx),
		.wr_address(addr_q),
		.wr_port   (port_q),
		.wr_idle   (wr_idle),
		.wr_btn    (btn_q),
		.used      (used),
		.rd_address(rd_address),
		.rd_port   (rd_port),
		.rd_idle   (rd_idle),
		.rd_btn    (rd_btn)
	);

	cst_alu u_alu (
		.st_address(rd_address),
		.st_port   (rd_port),
		.address   (addr_q),
		.port      (port_q),
		.idle      (rd_idle),
		.timeout   (timeout_q),
		.match     (match),
		.idle_inc  (idle_inc),
		.expired   (expired)
	);

	assign named_idx = named_q[IW-1:0];
	assign in_range  = named_q < 16'(SLOTS);
	assign hit       = in_range && match;
	assign in_stall  = (state_q != ST_IDLE);

	// slots 0..3 only
	always_comb begin
		mask_now = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < SLOTS) mask_now[i] = used[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state and store commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		rd_idx       = idx_q;
		wr_idx       = idx_q;
		wr_idle      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (func) inside
						FUNC_JOIN:              state_d = ST_JOIN_SCAN;
						FUNC_LEAVE, FUNC_INPUT: state_d = ST_NAMED_READ;
						default:                state_d = ST_TICK;
					endcase
				end
			end
			ST_JOIN_SCAN: begin
				if (!used[idx_q]) begin
					// claim slot; stays free when joining from address zero
					cmd.ep_we    = 1'b1;
					cmd.idle_we  = 1'b1;
					cmd.used_we  = 1'b1;
					cmd.used_val = (addr_q != 32'd0);
					cmd.rd       = 1'b1;
					state_d      = ST_JOIN_READ;
				end else if (idx_q == LAST) begin
					state_d = ST_RESULT;
				end
			end
			ST_JOIN_READ: state_d = ST_RESULT;
			ST_NAMED_READ: begin
				cmd.rd  = 1'b1;
				rd_idx  = named_idx;
				state_d = ST_NAMED_EXEC;
			end
			ST_NAMED_EXEC: begin
				wr_idx = named_idx;
				if (hit) begin
					if (func_q == FUNC_LEAVE) begin
						cmd.used_we  = 1'b1;
						cmd.used_val = 1'b0;
					end else begin
						cmd.btn_we  = 1'b1;
						cmd.idle_we = 1'b1;
					end
				end
				state_d = ST_RESULT;
			end
			ST_TICK: begin
				// read slot idx_q while updating slot idx_s1
				cmd.rd = !tick_done_q;
				if (vld_s1 && used[idx_s1]) begin
					wr_idx      = idx_s1;
					wr_idle     = idle_inc;
					cmd.idle_we = 1'b1;
					if (expired) begin
						cmd.used_we  = 1'b1;
						cmd.used_val = 1'b0;
					end
				end
				if (tick_done_q && !vld_s1) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			tick_done_q <= 1'b0;
			vld_s1      <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
		end else begin
			if (cfg_we) timeout_q <= cfg_data;
			if (state_q == ST_RESULT && state_d == ST_IDLE) out_valid_q <= 1'b1;
			else if (!out_stall)                            out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q       <= '0;
					tick_done_q <= 1'b0;
					vld_s1      <= 1'b0;
				end
				ST_JOIN_SCAN: begin
					if (used[idx_q] && idx_q != LAST) idx_q <= idx_q + 1'b1;
				end
				ST_TICK: begin
					vld_s1 <= !tick_done_q;
					if (!tick_done_q) begin
						if (idx_q == LAST) tick_done_q <= 1'b1;
						else               idx_q <= idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					func_q     <= func;
					addr_q     <= client_address;
					port_q     <= client_port;
					named_q    <= slot_index;
					btn_q      <= button_bits;
					res_acc_q  <= 1'b0;
					res_slot_q <= '0;
					res_btn_q  <= '0;
				end
			end
			ST_JOIN_SCAN: begin
				if (!used[idx_q]) begin
					res_acc_q  <= 1'b1;
					res_slot_q <= 2'(idx_q);
				end
			end
			ST_JOIN_READ: res_btn_q <= rd_btn;
			ST_NAMED_EXEC: begin
				res_acc_q  <= hit;
				res_slot_q <= named_q[1:0];
				if (!in_range)                       res_btn_q <= 4'd0;
				else if (hit && func_q == FUNC_INPUT) res_btn_q <= btn_q;
				else                                  res_btn_q <= rd_btn;
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					acc_out_q  <= res_acc_q;
					slot_out_q <= res_slot_q;
					btn_out_q  <= res_btn_q;
					mask_out_q <= mask_now;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign accepted      = acc_out_q;
	assign assigned_slot = slot_out_q;
	assign slot_buttons  = btn_out_q;
	assign active_mask   = mask_out_q;

endmodule

[tb/sv/client_slot_table_checker.sv]
// Checker for the client slot table: tracks the table and compares every result word.
module slot_table_checker #(
	parameter int SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] client_address,
	input  logic [15:0] client_port,
	input  logic [15:0] slot_index,
	input  logic [3:0]  button_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        accepted,
	input  logic [1:0]  assigned_slot,
	input  logic [3:0]  slot_buttons,
	input  logic [3:0]  active_mask,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import cst_pkg::*;

	typedef struct packed {
		logic       accepted;
		logic [1:0] slot;
		logic [3:0] buttons;
		logic [3:0] mask;
	} slot_result_t;

	logic [31:0] tbl_addr [SLOTS];
	logic [15:0] tbl_port [SLOTS];
	logic [15:0] tbl_idle [SLOTS];
	logic [3:0]  tbl_btn  [SLOTS];
	logic [15:0] timeout;

	slot_result_t expected_q[$];
	int fails;

	// table update for one word, returns the result word it should produce
	task automatic apply_word(input logic [1:0] f, input logic [31:0] a, input logic [15:0] p,
			input logic [15:0] idx, input logic [3:0] b, output slot_result_t r);
		int i;
		int s;
		logic found;
		r = '0;
		found = 1'b0;
		s = int'(idx);
		case (f) inside
			FUNC_JOIN: begin
				for (i = 0; i < SLOTS; i++) begin
					if (!found && tbl_addr[i] == 32'd0) begin
						tbl_addr[i] = a;
						tbl_port[i] = p;
						tbl_idle[i] = 16'd0;
						found = 1'b1;
						r.accepted = 1'b1;
						r.slot = i[1:0];
						r.buttons = tbl_btn[i];
					end
				end
			end
			FUNC_LEAVE, FUNC_INPUT: begin
				r.slot = idx[1:0];
				if (s < SLOTS) begin
					if (tbl_addr[s] == a && tbl_port[s] == p) begin
						r.accepted = 1'b1;
						if (f == FUNC_LEAVE)
							tbl_addr[s] = 32'd0;
						else begin
							tbl_btn[s] = b;
							tbl_idle[s] = 16'd0;
						end
					end
					r.buttons = tbl_btn[s];
				end
			end
			default: begin
				for (i = 0; i < SLOTS; i++) begin
					if (tbl_addr[i] != 32'd0) begin
						if (tbl_idle[i] != IDLE_MAX)
							tbl_idle[i] = tbl_idle[i] + 16'd1;
						if (tbl_idle[i] > timeout)
							tbl_addr[i] = 32'd0;
					end
				end
			end
		endcase
		for (i = 0; i < SLOTS && i < 4; i++)
			r.mask[i] = (tbl_addr[i] != 32'd0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_result_t got;
		slot_result_t want;
		slot_result_t fresh;
		int i;
		if (!arst_n) begin
			for (i = 0; i < SLOTS; i++) begin
				tbl_addr[i] = 32'd0;
				tbl_port[i] = 16'd0;
				tbl_idle[i] = 16'd0;
				tbl_btn[i] = 4'd0;
			end
			timeout = TIMEOUT_RESET;
			expected_q.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result side first: it belongs to a word taken earlier
			if (out_valid && !out_stall) begin
				got = '{accepted, assigned_slot, slot_buttons, active_mask};
				if (expected_q.size() == 0) begin
					if (fails < 10)
						$display("unexpected result word: acc=%0d slot=%0d btn=%h mask=%h",
							got.accepted, got.slot, got.buttons, got.mask);
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (got.accepted !== want.accepted || got.slot !== want.slot ||
							got.buttons !== want.buttons || got.mask !== want.mask) begin
						if (fails < 10)
							$display({"result mismatch: expected acc=%0d slot=%0d btn=%h mask=%h,",
								" got acc=%0d slot=%0d btn=%h mask=%h"},
								want.accepted, want.slot, want.buttons, want.mask,
								got.accepted, got.slot, got.buttons, got.mask);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_word(func, client_address, client_port, slot_index, button_bits, fresh);
				expected_q.push_back(fresh);
			end
			if (cfg_we)
				timeout = cfg_data;
			fail_count <= fails;
			pending <= expected_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench top for the client slot table: stimulus, idling and verdict.
module tb;
	import cst_pkg::*;

	localparam int SLOTS = 4;
	// bound for the watchdog on the length of the whole run
	localparam int CYCLE_LIMIT = 200_000;
	localparam int PHASE_WORDS = 170;
	// ticks in the tail: enough to push the idle counts past a small timeout
	localparam int TAIL_TICKS = 8;

	// fixed endpoints for the directed part; extremes of address and port
	localparam logic [31:0] EP0_ADDR = 32'hFFFF_FFFF;
	localparam logic [15:0] EP0_PORT = 16'hFFFF;
	localparam logic [31:0] EP1_ADDR = 32'h0000_0001;
	localparam logic [15:0] EP1_PORT = 16'h0000;
	localparam logic [31:0] EP2_ADDR = 32'hC0A8_0102;
	localparam logic [15:0] EP2_PORT = 16'd5000;
	localparam logic [31:0] EP3_ADDR = 32'h8000_0000;
	localparam logic [15:0] EP3_PORT = 16'h8000;
	localparam logic [31:0] EP4_ADDR = 32'h0A00_0001;
	localparam logic [15:0] EP4_PORT = 16'd7777;
	localparam logic [15:0] ZERO_EP_PORT = 16'd1234;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [31:0] client_address;
	logic [15:0] client_port;
	logic [15:0] slot_index;
	logic [3:0]  button_bits;
	logic        out_valid;
	logic        out_stall;
	logic        accepted;
	logic [1:0]  assigned_slot;
	logic [3:0]  slot_buttons;
	logic [3:0]  active_mask;
	logic        cfg_we;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int cycle_count;
	int stall_left;
	logic quiet;          // set for the tail of the run: no idling on either side

	// endpoint pool for the random part; entries 0 and 1 share an address so
	// that port-only mismatches come up, entry 5 is sometimes address zero
	logic [31:0] pool_addr [6];
	logic [15:0] pool_port [6];

	client_slot_table_top #(
		.SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.client_address(client_address),
		.client_port(client_port),
		.slot_index(slot_index),
		.button_bits(button_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.assigned_slot(assigned_slot),
		.slot_buttons(slot_buttons),
		.active_mask(active_mask),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	slot_table_checker #(
		.SLOTS(SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.client_address(client_address),
		.client_port(client_port),
		.slot_index(slot_index),
		.button_bits(button_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.assigned_slot(assigned_slot),
		.slot_buttons(slot_buttons),
		.active_mask(active_mask),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// result side back-pressure: random bursts of stalled cycles, none when quiet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Present one word and hold it until taken. An optional random gap with
	// valid low comes first; with no gap valid simply stays high from the
	// previous word, so it gets one assignment per step.
	task automatic send_word(input logic [1:0] f, input logic [31:0] a, input logic [15:0] p,
			input logic [15:0] idx, input logic [3:0] b);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		client_address <= a;
		client_port <= p;
		slot_index <= idx;
		button_bits <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drop valid and wait until every issued word has its result back;
	// the first edge lets the checker count a word taken at this very edge
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// timeout is only written with the table idle
	task automatic write_timeout(input logic [15:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic refill_pool();
		int k;
		for (k = 0; k < 6; k++) begin
			pool_addr[k] = $urandom;
			pool_port[k] = 16'($urandom_range(0, 65535));
		end
		pool_addr[1] = pool_addr[0];
		if ($urandom_range(0, 1) == 1)
			pool_addr[5] = 32'd0;
	endtask

	// Mostly pool endpoints so joins, leaves and inputs actually hit live
	// slots; a tenth are random endpoints and a tenth name a slot anywhere
	// in the 16-bit range, most of those out of range.
	task automatic random_word();
		int r;
		int k;
		logic [1:0]  f;
		logic [31:0] a;
		logic [15:0] p;
		logic [15:0] idx;
		logic [3:0]  b;
		k = $urandom_range(0, 5);
		a = pool_addr[k];
		p = pool_port[k];
		if ($urandom_range(0, 9) == 0) begin
			a = $urandom;
			p = 16'($urandom_range(0, 65535));
		end
		if ($urandom_range(0, 9) == 0)
			idx = 16'($urandom_range(0, 65535));
		else
			idx = 16'($urandom_range(0, SLOTS - 1));
		b = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 30)
			f = FUNC_JOIN;
		else if (r < 45)
			f = FUNC_LEAVE;
		else if (r < 80)
			f = FUNC_INPUT;
		else
			f = FUNC_TICK;
		send_word(f, a, p, idx, b);
	endtask

	initial begin
		logic [15:0] phase_timeout [7];
		int ph;
		int k;

		// every block input known from time zero
		arst_n = 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_TICK;
		client_address <= 32'd0;
		client_port <= 16'd0;
		slot_index <= 16'd0;
		button_bits <= 4'd0;
		cfg_we <= 1'b0;
		cfg_data <= 16'd0;
		quiet <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, timeout at its reset value ---
		// fill the table in order; this also writes every slot's port, so
		// leave/input from address zero is safe from here on
		send_word(FUNC_JOIN, EP0_ADDR, EP0_PORT, 16'd0, 4'd0);
		send_word(FUNC_JOIN, EP1_ADDR, EP1_PORT, 16'd0, 4'd0);
		send_word(FUNC_JOIN, EP2_ADDR, EP2_PORT, 16'd0, 4'd0);
		send_word(FUNC_JOIN, EP3_ADDR, EP3_PORT, 16'd0, 4'd0);
		send_word(FUNC_JOIN, EP4_ADDR, EP4_PORT, 16'd0, 4'd0);         // table full
		send_word(FUNC_INPUT, EP2_ADDR, EP2_PORT, 16'd2, 4'hF);
		send_word(FUNC_INPUT, EP1_ADDR, 16'd1, 16'd1, 4'h3);            // port differs
		send_word(FUNC_INPUT, EP0_ADDR, EP0_PORT, 16'd4, 4'h7);         // just out of range
		send_word(FUNC_LEAVE, EP0_ADDR, EP0_PORT, 16'hFFFF, 4'd0);      // far out of range
		send_word(FUNC_LEAVE, EP3_ADDR, EP3_PORT, 16'd2, 4'd0);         // wrong endpoint
		send_word(FUNC_LEAVE, EP2_ADDR, EP2_PORT, 16'd2, 4'd0);
		// join from address zero: endpoint stored, slot stays free, buttons kept
		send_word(FUNC_JOIN, 32'd0, ZERO_EP_PORT, 16'd0, 4'd0);
		send_word(FUNC_INPUT, 32'd0, ZERO_EP_PORT, 16'd2, 4'h5);
		send_word(FUNC_LEAVE, 32'd0, ZERO_EP_PORT, 16'd2, 4'd0);
		send_word(FUNC_JOIN, EP4_ADDR, EP4_PORT, 16'd0, 4'd0);          // sees kept buttons
		send_word(FUNC_INPUT, EP0_ADDR, EP0_PORT, 16'd0, 4'h0);
		send_word(FUNC_TICK, 32'd0, 16'd0, 16'd0, 4'd0);
		send_word(FUNC_INPUT, EP3_ADDR, EP3_PORT, 16'd3, 4'hA);
		// timeout zero: every used slot goes at its first tick
		write_timeout(16'd0);
		send_word(FUNC_TICK, 32'd0, 16'd0, 16'd0, 4'd0);
		// timeout one: survives one tick, freed on the second
		write_timeout(16'd1);
		send_word(FUNC_JOIN, EP0_ADDR, EP0_PORT, 16'd0, 4'd0);
		send_word(FUNC_TICK, 32'd0, 16'd0, 16'd0, 4'd0);
		send_word(FUNC_TICK, 32'd0, 16'd0, 16'd0, 4'd0);
		send_word(FUNC_JOIN, EP1_ADDR, EP1_PORT, 16'd0, 4'd0);
		send_word(FUNC_INPUT, EP1_ADDR, EP1_PORT, 16'd0, 4'h3);

		// --- random part: one phase per timeout setting ---
		phase_timeout[0] = 16'($urandom_range(2, 10));
		phase_timeout[1] = 16'd1;
		phase_timeout[2] = TIMEOUT_RESET;
		phase_timeout[3] = 16'hFFFF;
		phase_timeout[4] = 16'($urandom_range(11, 65534));
		phase_timeout[5] = 16'd0;
		phase_timeout[6] = 16'd5;
		for (ph = 0; ph < 7; ph++) begin
			write_timeout(phase_timeout[ph]);
			refill_pool();
			for (k = 0; k < PHASE_WORDS; k++)
				random_word();
		end

		// --- tail: no idling; fill the table, age it, then lower the timeout ---
		quiet <= 1'b1;
		write_timeout(16'hFFFF);
		refill_pool();
		for (k = 0; k < SLOTS; k++)
			send_word(FUNC_JOIN, pool_addr[k], pool_port[k], 16'd0, 4'd0);
		for (k = 0; k < TAIL_TICKS; k++)
			send_word(FUNC_TICK, 32'd0, 16'd0, 16'd0, 4'd0);
		// counts already above the new timeout are freed at the next tick
		write_timeout(16'd4);
		send_word(FUNC_TICK, 32'd0, 16'd0, 16'd0, 4'd0);
		for (k = 0; k < 20; k++)
			random_word();

		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
